/* src/ptsd_pkg.sv */
// Package for the PLATO terminal stream decoder: codes, widths and the job and result types.
// This package depends on nothing. Every other file of the decoder uses it.
package ptsd_pkg;

	localparam int GlyphRows = 8;
	localparam int RowW = $clog2(GlyphRows);

	// Output command codes
	localparam logic [4:0] C_TTY = 5'd0;
	localparam logic [4:0] C_TEXT = 5'd1;
	localparam logic [4:0] C_BLOCK = 5'd2;
	localparam logic [4:0] C_DOT = 5'd3;
	localparam logic [4:0] C_LINE = 5'd4;
	localparam logic [4:0] C_MEMLD = 5'd5;
	localparam logic [4:0] C_GLYPH = 5'd6;
	localparam logic [4:0] C_MODE5 = 5'd7;
	localparam logic [4:0] C_MODE6 = 5'd8;
	localparam logic [4:0] C_MODE7 = 5'd9;
	localparam logic [4:0] C_EXTOUT = 5'd10;
	localparam logic [4:0] C_ALLOW = 5'd11;
	localparam logic [4:0] C_SELIN = 5'd12;
	localparam logic [4:0] C_SELOUT = 5'd13;
	localparam logic [4:0] C_KEY = 5'd14;
	localparam logic [4:0] C_MEMRD = 5'd15;
	localparam logic [4:0] C_BEEP = 5'd16;
	localparam logic [4:0] C_CLEAR = 5'd17;
	localparam logic [4:0] C_ENTTY = 5'd18;
	localparam logic [4:0] C_ENPLATO = 5'd19;

	// Decoder modes
	localparam logic [4:0] M_TEXT = 5'd0;
	localparam logic [4:0] M_BLOCK = 5'd1;
	localparam logic [4:0] M_POINT = 5'd2;
	localparam logic [4:0] M_LINE = 5'd3;
	localparam logic [4:0] M_LCOORD = 5'd4;
	localparam logic [4:0] M_LADDR = 5'd5;
	localparam logic [4:0] M_SSF = 5'd6;
	localparam logic [4:0] M_EXT = 5'd7;
	localparam logic [4:0] M_ECHO = 5'd8;
	localparam logic [4:0] M_LCHAR = 5'd9;
	localparam logic [4:0] M_LMEM = 5'd10;
	localparam logic [4:0] M_MODE5 = 5'd11;
	localparam logic [4:0] M_MODE6 = 5'd12;
	localparam logic [4:0] M_MODE7 = 5'd13;
	localparam logic [4:0] M_FORE = 5'd14;
	localparam logic [4:0] M_BACK = 5'd15;
	localparam logic [4:0] M_PAINT = 5'd16;

	// Data types
	localparam logic [2:0] T_BYTE = 3'd0;
	localparam logic [2:0] T_WORD = 3'd1;
	localparam logic [2:0] T_COORD = 3'd2;
	localparam logic [2:0] T_COLOR = 3'd3;
	localparam logic [2:0] T_PAINT = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] R_WIDTH = 3'd0;
	localparam logic [2:0] R_HEIGHT = 3'd1;
	localparam logic [2:0] R_TYPE = 3'd2;
	localparam logic [2:0] R_SUBTYPE = 3'd3;
	localparam logic [2:0] R_LOADFILE = 3'd4;
	localparam logic [2:0] R_CONFIG = 3'd5;
	localparam logic [2:0] R_FONTBASE = 3'd6;

	// Job kinds
	localparam logic [1:0] K_ONE = 2'd0;
	localparam logic [1:0] K_TWO = 2'd1;
	localparam logic [1:0] K_GLYPH = 2'd2;

	localparam logic [6:0] ATTR_RESET = 7'h01;

	typedef struct packed {
		logic [4:0]      command;
		logic [10:0]     pos_x;
		logic [10:0]     pos_y;
		logic [10:0]     end_x;
		logic [10:0]     end_y;
		logic [15:0]     target_address;
		logic [15:0]     payload;
		logic [RowW-1:0] glyph_row;
		logic [6:0]      attributes;
	} res_t;

	typedef struct packed {
		logic [1:0]                 kind;
		res_t                       first;
		logic [4:0]                 cmd2;
		logic [15:0]                pay2;
		logic [GlyphRows-1:0][15:0] rows;
	} job_t;

	// One cursor step with a single wrap correction, kept modulo 2048.
	function automatic logic [10:0] wrap_axis(input logic [10:0] v, input logic [7:0] d,
			input logic [10:0] size);
		logic [13:0] n;
		n = {3'b000, v} + {{6{d[7]}}, d};
		if (n[13]) begin
			n = n + {3'b000, size};
		end else if (n >= {3'b000, size}) begin
			n = n - {3'b000, size};
		end
		return n[10:0];
	endfunction

endpackage

/* src/ptsd_front.sv */
// Front end of the decoder: accepts host bytes, keeps the protocol state and builds jobs.
// Depends on ptsd_pkg. Its jobs go to the queue in ptsd_queue.
module ptsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	output logic                push,
	output ptsd_pkg::job_t      job
);

	logic [10:0] sw_q, sh_q;
	logic [6:0]  ttype_q, tsub_q, lfile_q, ccode_q;
	logic [15:0] fbase_q;

	logic        tty_q, esc_q, second_q;
	logic [4:0]  pmode_q, cmd_q;
	logic [2:0]  ptype_q, ctype_q;
	logic [1:0]  phase_q;
	logic [15:0] word_q, maddr_q;
	logic [3:0][4:0] cp_q;
	logic [10:0] cx_q, cy_q, margin_q;
	logic [ptsd_pkg::RowW-1:0] gcnt_q;
	logic [ptsd_pkg::GlyphRows-1:0][15:0] grow_q;
	logic [6:0]  attr_q;

	logic        n_tty, n_esc, n_second;
	logic [4:0]  n_pmode, n_cmd;
	logic [2:0]  n_ptype, n_ctype;
	logic [1:0]  n_phase;
	logic [15:0] n_word, n_maddr;
	logic [3:0][4:0] n_cp;
	logic [10:0] n_cx, n_cy, n_margin;
	logic [ptsd_pkg::RowW-1:0] n_gcnt;
	logic [ptsd_pkg::GlyphRows-1:0][15:0] n_grow;
	logic [6:0]  n_attr;

	always_comb begin
		logic [6:0]  c;
		logic [4:0]  v;
		logic        fin, do_step;
		logic [10:0] bx, by, crdx, crdy;
		logic [7:0]  dx, dy, sx, sy;
		logic [15:0] w;
		logic [7:0]  dev;
		logic [15:0] gdiff;
		c = rx_byte[6:0];
		v = c[4:0];
		fin = 1'b0;
		do_step = 1'b0;
		bx = cx_q;
		by = cy_q;
		dx = 8'd0;
		dy = 8'd0;
		sx = 8'd0;
		sy = 8'd0;
		w = 16'd0;
		dev = 8'd0;
		gdiff = 16'd0;
		crdx = 11'd0;
		crdy = 11'd0;
		n_tty = tty_q; n_esc = esc_q; n_second = second_q;
		n_pmode = pmode_q; n_cmd = cmd_q; n_ptype = ptype_q; n_ctype = ctype_q;
		n_phase = phase_q; n_word = word_q; n_maddr = maddr_q; n_cp = cp_q;
		n_cx = cx_q; n_cy = cy_q; n_margin = margin_q; n_gcnt = gcnt_q;
		n_grow = grow_q; n_attr = attr_q;
		push = 1'b0;
		job = '0;
		job.kind = ptsd_pkg::K_ONE;
		job.first.attributes = attr_q;

		if (accept) begin
			if (tty_q) begin
				if (!esc_q) begin
					push = 1'b1;
					job.first.command = ptsd_pkg::C_TTY;
					job.first.payload = {9'd0, c};
				end else if (c == 7'h02) begin
					push = 1'b1;
					job.first.command = ptsd_pkg::C_ENPLATO;
					n_tty = 1'b0;
					n_pmode = ptsd_pkg::M_TEXT; n_ptype = ptsd_pkg::T_BYTE;
					n_cmd = ptsd_pkg::M_TEXT; n_ctype = ptsd_pkg::T_BYTE;
					n_second = 1'b0; n_phase = 2'd0;
					n_cp = '0; n_cx = 11'd0; n_cy = 11'd0; n_maddr = 16'd0;
					n_gcnt = '0; n_margin = 11'd0; n_attr = ptsd_pkg::ATTR_RESET;
				end
			end else if (esc_q) begin
				unique case (c)
					7'h03: begin
						n_tty = 1'b1;
						push = 1'b1;
						job.first.command = ptsd_pkg::C_ENTTY;
					end
					7'h0C: begin
						push = 1'b1;
						job.first.command = ptsd_pkg::C_CLEAR;
					end
					7'h11: n_attr[1:0] = 2'd3;
					7'h12: n_attr[1:0] = 2'd0;
					7'h13: n_attr[1:0] = 2'd2;
					7'h14: n_attr[1:0] = 2'd1;
					7'h32: begin
						n_cmd = ptsd_pkg::M_LCOORD; n_ctype = ptsd_pkg::T_COORD; n_phase = 2'd0;
					end
					7'h40: begin do_step = 1'b1; dy = 8'd5; end
					7'h41: begin do_step = 1'b1; dy = -8'sd5; end
					7'h42, 7'h43, 7'h44, 7'h45: n_attr[3:2] = c[1:0] - 2'd2;
					7'h4A: n_attr[5] = 1'b0;
					7'h4B: n_attr[5] = 1'b1;
					7'h4C: n_attr[6] = 1'b0;
					7'h4D: n_attr[6] = 1'b1;
					7'h4E: n_attr[4] = 1'b0;
					7'h4F: n_attr[4] = 1'b1;
					7'h50, 7'h53, 7'h54, 7'h55, 7'h56: begin
						case (c)
							7'h50: n_pmode = ptsd_pkg::M_LCHAR;
							7'h53: n_pmode = ptsd_pkg::M_LMEM;
							7'h54: n_pmode = ptsd_pkg::M_MODE5;
							7'h55: n_pmode = ptsd_pkg::M_MODE6;
							default: n_pmode = ptsd_pkg::M_MODE7;
						endcase
						n_ptype = ptsd_pkg::T_WORD; n_second = 1'b0;
						n_cmd = n_pmode; n_ctype = ptsd_pkg::T_WORD; n_phase = 2'd0;
					end
					7'h51, 7'h52, 7'h57, 7'h59: begin
						case (c)
							7'h51: n_cmd = ptsd_pkg::M_SSF;
							7'h52: n_cmd = ptsd_pkg::M_EXT;
							7'h57: n_cmd = ptsd_pkg::M_LADDR;
							default: n_cmd = ptsd_pkg::M_ECHO;
						endcase
						n_ctype = ptsd_pkg::T_WORD; n_phase = 2'd0;
					end
					7'h5A: n_margin = attr_q[5] ? cy_q : cx_q;
					7'h61: begin
						n_cmd = ptsd_pkg::M_FORE; n_ctype = ptsd_pkg::T_COLOR; n_phase = 2'd0;
					end
					7'h62: begin
						n_cmd = ptsd_pkg::M_BACK; n_ctype = ptsd_pkg::T_COLOR; n_phase = 2'd0;
					end
					7'h63: begin
						n_cmd = ptsd_pkg::M_PAINT; n_ctype = ptsd_pkg::T_PAINT; n_phase = 2'd0;
					end
					default: ;
				endcase
			end else if (c < 7'h20) begin
				unique case (c)
					7'h08: begin do_step = 1'b1; dx = -8'sd8; end
					7'h09: begin do_step = 1'b1; dx = 8'd8; end
					7'h0A: begin do_step = 1'b1; dy = -8'sd16; end
					7'h0B: begin do_step = 1'b1; dy = 8'd16; end
					7'h0C: begin
						bx = 11'd0; by = 11'd0; do_step = 1'b1; dy = -8'sd16;
					end
					7'h0D: begin
						if (attr_q[5]) by = margin_q; else bx = margin_q;
						do_step = 1'b1; dy = -8'sd16;
					end
					7'h19, 7'h1C, 7'h1D, 7'h1F: begin
						case (c)
							7'h19: begin n_pmode = ptsd_pkg::M_BLOCK; n_ptype = ptsd_pkg::T_COORD; end
							7'h1C: begin n_pmode = ptsd_pkg::M_POINT; n_ptype = ptsd_pkg::T_COORD; end
							7'h1D: begin n_pmode = ptsd_pkg::M_LINE; n_ptype = ptsd_pkg::T_COORD; end
							default: begin n_pmode = ptsd_pkg::M_TEXT; n_ptype = ptsd_pkg::T_BYTE; end
						endcase
						n_second = 1'b0; n_cmd = n_pmode; n_ctype = n_ptype; n_phase = 2'd0;
					end
					default: ;
				endcase
			end else begin
				case (ctype_q)
					ptsd_pkg::T_BYTE: begin
						push = 1'b1;
						job.first.command = ptsd_pkg::C_TEXT;
						job.first.pos_x = cx_q; job.first.pos_y = cy_q;
						job.first.payload = {9'd0, c};
						do_step = 1'b1; dx = 8'd8;
					end
					ptsd_pkg::T_WORD: begin
						case (phase_q)
							2'd0: begin n_word = {10'd0, c[5:0]}; n_phase = 2'd1; end
							2'd1: begin n_word = word_q | {4'd0, c[5:0], 6'd0}; n_phase = 2'd2; end
							2'd2: begin n_word = word_q | {c[3:0], 12'd0}; fin = 1'b1; end
							default: ;
						endcase
					end
					ptsd_pkg::T_COORD: begin
						case (c[6:5])
							2'd1: begin
								if (phase_q == 2'd0) n_cp[3] = v;
								else if (phase_q == 2'd1) n_cp[1] = v;
								n_phase = 2'd1;
							end
							2'd2: begin n_cp[0] = v; fin = 1'b1; end
							2'd3: begin n_cp[2] = v; n_phase = 2'd1; end
							default: ;
						endcase
					end
					ptsd_pkg::T_COLOR: begin
						if (phase_q < 2'd3) n_phase = phase_q + 2'd1; else fin = 1'b1;
					end
					ptsd_pkg::T_PAINT: begin
						if (phase_q == 2'd0) n_phase = 2'd1; else fin = 1'b1;
					end
					default: ;
				endcase

				if (fin) begin
					w = n_word;
					crdx = {1'b0, n_cp[1], n_cp[0]};
					crdy = {1'b0, n_cp[3], n_cp[2]};
					dev = {2'b00, w[15:10]};
					case (cmd_q)
						ptsd_pkg::M_BLOCK: begin
							if (!second_q) begin
								n_cx = crdx; n_cy = crdy; n_second = 1'b1;
							end else begin
								push = 1'b1;
								job.first.command = ptsd_pkg::C_BLOCK;
								job.first.pos_x = cx_q; job.first.pos_y = cy_q;
								job.first.end_x = crdx; job.first.end_y = crdy;
								n_second = 1'b0;
							end
						end
						ptsd_pkg::M_POINT: begin
							n_cx = crdx; n_cy = crdy;
							push = 1'b1;
							job.first.command = ptsd_pkg::C_DOT;
							job.first.pos_x = crdx; job.first.pos_y = crdy;
						end
						ptsd_pkg::M_LINE: begin
							n_cx = crdx; n_cy = crdy;
							if (!second_q) begin
								n_second = 1'b1;
							end else begin
								push = 1'b1;
								job.first.command = ptsd_pkg::C_LINE;
								job.first.pos_x = cx_q; job.first.pos_y = cy_q;
								job.first.end_x = crdx; job.first.end_y = crdy;
							end
						end
						ptsd_pkg::M_TEXT: begin
							push = 1'b1;
							job.first.command = ptsd_pkg::C_TEXT;
							job.first.pos_x = cx_q; job.first.pos_y = cy_q;
							job.first.payload = {9'd0, c};
							do_step = 1'b1; dx = 8'd8;
						end
						ptsd_pkg::M_LCOORD: begin n_cx = crdx; n_cy = crdy; end
						ptsd_pkg::M_LADDR: begin n_maddr = w; n_gcnt = '0; end
						ptsd_pkg::M_SSF: begin
							push = 1'b1;
							if (dev == 8'd1) begin
								job.first.command = ptsd_pkg::C_ALLOW;
								job.first.payload = {14'd0, w[5], w[3]};
							end else if (w[9]) begin
								job.first.command = ptsd_pkg::C_SELIN;
								job.first.target_address = {8'd0, dev};
								job.first.payload = {15'd0, ~w[8]};
							end else begin
								job.first.command = ptsd_pkg::C_SELOUT;
								job.first.target_address = {8'd0, dev};
								if (!w[8]) begin
									job.kind = ptsd_pkg::K_TWO;
									job.cmd2 = ptsd_pkg::C_EXTOUT;
									job.pay2 = {8'd0, w[7:0]};
								end
							end
						end
						ptsd_pkg::M_EXT: begin
							push = 1'b1;
							job.kind = ptsd_pkg::K_TWO;
							job.first.command = ptsd_pkg::C_EXTOUT;
							job.first.payload = {8'd0, w[15:8]};
							job.cmd2 = ptsd_pkg::C_EXTOUT;
							job.pay2 = {8'd0, w[7:0]};
						end
						ptsd_pkg::M_ECHO: begin
							push = 1'b1;
							job.first.command = ptsd_pkg::C_KEY;
							case (w[6:0])
								7'h52: job.first.payload = 16'h00D3;
								7'h70: job.first.payload = {9'h001, ttype_q};
								7'h71: job.first.payload = {9'h001, tsub_q};
								7'h72: job.first.payload = {9'h001, lfile_q};
								7'h73: job.first.payload = {9'h001, ccode_q};
								7'h7A: job.first.payload = 16'h03FF;
								7'h7B: job.first.command = ptsd_pkg::C_BEEP;
								7'h7D: begin
									job.first.command = ptsd_pkg::C_MEMRD;
									job.first.target_address = maddr_q;
								end
								default: job.first.payload = {9'h001, w[6:0]};
							endcase
						end
						ptsd_pkg::M_LCHAR: begin
							n_grow[gcnt_q] = w;
							if (gcnt_q != ptsd_pkg::RowW'(ptsd_pkg::GlyphRows - 1)) begin
								n_gcnt = gcnt_q + 1'b1;
							end else begin
								push = 1'b1;
								job.kind = ptsd_pkg::K_GLYPH;
								job.first.command = ptsd_pkg::C_GLYPH;
								// The glyph number is the offset from the font base in
								// 16-byte units, kept to seven bits.
								gdiff = maddr_q - fbase_q;
								job.first.target_address = {9'd0, gdiff[10:4]};
								job.rows = n_grow;
								n_gcnt = '0;
								n_maddr = maddr_q + 16'd16;
							end
						end
						ptsd_pkg::M_LMEM: begin
							push = 1'b1;
							job.first.command = ptsd_pkg::C_MEMLD;
							job.first.target_address = maddr_q;
							job.first.payload = w;
							n_maddr = maddr_q + 16'd2;
						end
						ptsd_pkg::M_MODE5, ptsd_pkg::M_MODE6, ptsd_pkg::M_MODE7: begin
							push = 1'b1;
							job.first.command = ptsd_pkg::C_MODE5 + (cmd_q - ptsd_pkg::M_MODE5);
							job.first.payload = w;
						end
						default: ;
					endcase
					n_cmd = pmode_q; n_ctype = ptsd_pkg::T_BYTE | ptype_q; n_phase = 2'd0;
				end
			end

			if (do_step) begin
				sx = attr_q[4] ? {dx[6:0], 1'b0} : dx;
				sy = attr_q[4] ? {dy[6:0], 1'b0} : dy;
				if (attr_q[6]) sx = -sx;
				if (attr_q[5]) begin
					n_cx = ptsd_pkg::wrap_axis(bx, sy, sw_q);
					n_cy = ptsd_pkg::wrap_axis(by, sx, sh_q);
				end else begin
					n_cx = ptsd_pkg::wrap_axis(bx, sx, sw_q);
					n_cy = ptsd_pkg::wrap_axis(by, sy, sh_q);
				end
			end
			n_esc = (c == 7'h1B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= 11'd512; sh_q <= 11'd512;
			ttype_q <= 7'd0; tsub_q <= 7'd0; lfile_q <= 7'd0; ccode_q <= 7'd0;
			fbase_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptsd_pkg::R_WIDTH: sw_q <= cfg_wdata[10:0];
				ptsd_pkg::R_HEIGHT: sh_q <= cfg_wdata[10:0];
				ptsd_pkg::R_TYPE: ttype_q <= cfg_wdata[6:0];
				ptsd_pkg::R_SUBTYPE: tsub_q <= cfg_wdata[6:0];
				ptsd_pkg::R_LOADFILE: lfile_q <= cfg_wdata[6:0];
				ptsd_pkg::R_CONFIG: ccode_q <= cfg_wdata[6:0];
				ptsd_pkg::R_FONTBASE: fbase_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tty_q <= 1'b1; esc_q <= 1'b0; second_q <= 1'b0;
			pmode_q <= ptsd_pkg::M_TEXT; cmd_q <= ptsd_pkg::M_TEXT;
			ptype_q <= ptsd_pkg::T_BYTE; ctype_q <= ptsd_pkg::T_BYTE;
			phase_q <= 2'd0; word_q <= 16'd0; maddr_q <= 16'd0; cp_q <= '0;
			cx_q <= 11'd0; cy_q <= 11'd0; margin_q <= 11'd0; gcnt_q <= '0;
			attr_q <= ptsd_pkg::ATTR_RESET;
		end else begin
			tty_q <= n_tty; esc_q <= n_esc; second_q <= n_second;
			pmode_q <= n_pmode; cmd_q <= n_cmd; ptype_q <= n_ptype; ctype_q <= n_ctype;
			phase_q <= n_phase; word_q <= n_word; maddr_q <= n_maddr; cp_q <= n_cp;
			cx_q <= n_cx; cy_q <= n_cy; margin_q <= n_margin; gcnt_q <= n_gcnt;
			attr_q <= n_attr;
		end
	end

	// Glyph rows need no reset: each is written before a glyph is sent.
	always_ff @(posedge clk) begin
		grow_q <= n_grow;
	end

endmodule

/* src/ptsd_queue.sv */
// Two-entry job queue between the front and back ends of the decoder.
// Depends on ptsd_pkg for the job type.
module ptsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptsd_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output ptsd_pkg::job_t rd_job
);

	ptsd_pkg::job_t slot_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_job = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0; rptr_q <= 1'b0; count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wr_job;
	end

endmodule

/* src/ptsd_back.sv */
// Back end of the decoder: expands each job into its results and holds the output register.
// Depends on ptsd_pkg for the job and result types.
module ptsd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  ptsd_pkg::job_t q_job,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output ptsd_pkg::res_t res,
	output logic           res_last
);

	logic                      busy_q, out_valid_q, last_q;
	ptsd_pkg::job_t            job_q;
	logic [ptsd_pkg::RowW-1:0] idx_q;
	ptsd_pkg::res_t            res_q, r;
	logic                      fin, load;

	assign pop = !busy_q && q_not_empty;
	assign load = busy_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res = res_q;
	assign res_last = last_q;

	always_comb begin
		r = job_q.first;
		fin = 1'b1;
		case (job_q.kind)
			ptsd_pkg::K_TWO: begin
				fin = (idx_q != '0);
				if (idx_q != '0) begin
					r.command = job_q.cmd2;
					r.payload = job_q.pay2;
					r.target_address = 16'd0;
				end
			end
			ptsd_pkg::K_GLYPH: begin
				fin = (idx_q == ptsd_pkg::RowW'(ptsd_pkg::GlyphRows - 1));
				r.payload = job_q.rows[idx_q];
				r.glyph_row = idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; out_valid_q <= 1'b0; idx_q <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
				if (fin) busy_q <= 1'b0;
			end
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= q_job;
		if (load) begin
			res_q <= r;
			last_q <= fin;
		end
	end

endmodule

/* src/plato_terminal_stream_decoder_top.sv */
// Top level of the PLATO terminal stream decoder: front end, job queue and back end.
// A byte that causes results is written into a queue slot, fetched into the back end's job
// register and then loaded into the output register as its first result.
// Throughput: one byte per cycle while the queue has room; the back end fetches a job, then
// loads its results one at a time, and fetches no new job until its last result is loaded.
// Reset (arst_n low, asynchronous) puts the decoder in TTY mode with empty queue and output.
// Depends on ptsd_pkg, ptsd_front, ptsd_queue and ptsd_back.
module plato_terminal_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  command,
	output logic [10:0] pos_x,
	output logic [10:0] pos_y,
	output logic [10:0] end_x,
	output logic [10:0] end_y,
	output logic [15:0] target_address,
	output logic [15:0] payload,
	output logic [2:0]  glyph_row,
	output logic [6:0]  attributes,
	output logic        last
);

	logic           push, q_full, q_not_empty, pop;
	ptsd_pkg::job_t f_job, q_job;
	ptsd_pkg::res_t res;

	// The front end takes a byte whenever the queue can hold whatever job it makes.
	assign in_stall = q_full;

	ptsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_valid && !q_full),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.job       (f_job)
	);

	ptsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (f_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_job    (q_job)
	);

	// The back end turns each job into one, two or eight result transfers.
	ptsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_job       (q_job),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.res         (res),
		.res_last    (last)
	);

	assign command = res.command;
	assign pos_x = res.pos_x;
	assign pos_y = res.pos_y;
	assign end_x = res.end_x;
	assign end_y = res.end_y;
	assign target_address = res.target_address;
	assign payload = res.payload;
	assign glyph_row = res.glyph_row;
	assign attributes = res.attributes;

endmodule

/* sim/ptsd_tb_pkg.sv */
// Protocol byte codes shared by the decoder testbench and its checker.
// Depends on nothing; the stimulus and the checker both import it.
package ptsd_tb_pkg;

	localparam logic [6:0] B_STX = 7'h02;
	localparam logic [6:0] B_ETX = 7'h03;
	localparam logic [6:0] B_ESC = 7'h1B;

	// Control codes in PLATO mode
	localparam logic [6:0] CT_BS = 7'h08;
	localparam logic [6:0] CT_HT = 7'h09;
	localparam logic [6:0] CT_LF = 7'h0A;
	localparam logic [6:0] CT_VT = 7'h0B;
	localparam logic [6:0] CT_FF = 7'h0C;
	localparam logic [6:0] CT_CR = 7'h0D;
	localparam logic [6:0] CT_BLOCK = 7'h19;
	localparam logic [6:0] CT_POINT = 7'h1C;
	localparam logic [6:0] CT_LINE = 7'h1D;
	localparam logic [6:0] CT_TEXT = 7'h1F;

	// Codes that follow an escape
	localparam logic [6:0] E_CLEAR = 7'h0C;
	localparam logic [6:0] E_INVERSE = 7'h11;
	localparam logic [6:0] E_WRITE = 7'h12;
	localparam logic [6:0] E_ERASE = 7'h13;
	localparam logic [6:0] E_REWRITE = 7'h14;
	localparam logic [6:0] E_LDCOORD = 7'h32;
	localparam logic [6:0] E_UP = 7'h40;
	localparam logic [6:0] E_DOWN = 7'h41;
	localparam logic [6:0] E_FONT0 = 7'h42;
	localparam logic [6:0] E_FONT3 = 7'h45;
	localparam logic [6:0] E_ROT_OFF = 7'h4A;
	localparam logic [6:0] E_ROT_ON = 7'h4B;
	localparam logic [6:0] E_REV_OFF = 7'h4C;
	localparam logic [6:0] E_REV_ON = 7'h4D;
	localparam logic [6:0] E_BOLD_OFF = 7'h4E;
	localparam logic [6:0] E_BOLD_ON = 7'h4F;
	localparam logic [6:0] E_LDCHAR = 7'h50;
	localparam logic [6:0] E_SSF = 7'h51;
	localparam logic [6:0] E_EXT = 7'h52;
	localparam logic [6:0] E_LDMEM = 7'h53;
	localparam logic [6:0] E_MODE5 = 7'h54;
	localparam logic [6:0] E_MODE6 = 7'h55;
	localparam logic [6:0] E_MODE7 = 7'h56;
	localparam logic [6:0] E_LDADDR = 7'h57;
	localparam logic [6:0] E_ECHO = 7'h59;
	localparam logic [6:0] E_MARGIN = 7'h5A;
	localparam logic [6:0] E_FORE = 7'h61;
	localparam logic [6:0] E_BACK = 7'h62;
	localparam logic [6:0] E_PAINT = 7'h63;

	// Echo queries
	localparam logic [6:0] Q_FLOW = 7'h52;
	localparam logic [6:0] Q_TYPE = 7'h70;
	localparam logic [6:0] Q_SUBTYPE = 7'h71;
	localparam logic [6:0] Q_LOADFILE = 7'h72;
	localparam logic [6:0] Q_CONFIG = 7'h73;
	localparam logic [6:0] Q_BACKOUT = 7'h7A;
	localparam logic [6:0] Q_BEEP = 7'h7B;
	localparam logic [6:0] Q_MEMREAD = 7'h7D;

endpackage

/* sim/ptsd_checker.sv */
// Checker for the PLATO terminal stream decoder: watches both channels and the register port,
// predicts every result and compares it. Depends on ptsd_pkg and ptsd_tb_pkg.
module ptsd_checker
	import ptsd_pkg::*;
	import ptsd_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  command,
	input  logic [10:0] pos_x,
	input  logic [10:0] pos_y,
	input  logic [10:0] end_x,
	input  logic [10:0] end_y,
	input  logic [15:0] target_address,
	input  logic [15:0] payload,
	input  logic [2:0]  glyph_row,
	input  logic [6:0]  attributes,
	input  logic        last,
	output int          fails,
	output int          results_due,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [4:0]  command;
		logic [10:0] px, py, ex, ey;
		logic [15:0] tgt, pay;
		logic [2:0]  row;
		logic [6:0]  attr;
		logic        lst;
	} decoded_t;

	decoded_t pending_results[$];
	decoded_t byte_results[$];

	int          scr_w, scr_h;
	logic [6:0]  ans_type, ans_sub, ans_load, ans_cfg;
	logic [15:0] font_base;

	bit          in_tty, esc_seen, second_pt, flow_on;
	logic [4:0]  pmode, cmode;
	logic [2:0]  ptype, ctype;
	int          ph, cur_x, cur_y, margin_pos, row_cnt;
	int          parts[4];
	logic [15:0] word, mem_addr;
	logic [15:0] rows[GlyphRows];
	logic [6:0]  attr;

	function automatic void put(logic [4:0] cmd, int px, int py, int ex, int ey,
			int tgt, int pay, int row);
		decoded_t r;
		r.command = cmd;
		r.px = px[10:0];
		r.py = py[10:0];
		r.ex = ex[10:0];
		r.ey = ey[10:0];
		r.tgt = tgt[15:0];
		r.pay = pay[15:0];
		r.row = row[2:0];
		r.attr = attr;
		r.lst = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic int wrap(int v, int d, int size);
		int n;
		n = v + d;
		if (n < 0) n += size;
		else if (n >= size) n -= size;
		return n & 'h7FF;
	endfunction

	function automatic void move_cursor(int dx, int dy);
		if (attr[4]) begin
			dx *= 2;
			dy *= 2;
		end
		if (attr[6]) dx = -dx;
		if (attr[5]) begin
			cur_x = wrap(cur_x, dy, scr_w);
			cur_y = wrap(cur_y, dx, scr_h);
		end else begin
			cur_x = wrap(cur_x, dx, scr_w);
			cur_y = wrap(cur_y, dy, scr_h);
		end
	endfunction

	function automatic void begin_command(logic [4:0] m, logic [2:0] t);
		cmode = m;
		ctype = t;
		ph = 0;
	endfunction

	function automatic void begin_mode(logic [4:0] m, logic [2:0] t);
		pmode = m;
		ptype = t;
		second_pt = 0;
		begin_command(m, t);
	endfunction

	function automatic int coord_x();
		return ((parts[1] << 5) + parts[0]) & 'h3FF;
	endfunction

	function automatic int coord_y();
		return ((parts[3] << 5) + parts[2]) & 'h3FF;
	endfunction

	function automatic void text_char(logic [6:0] c);
		put(C_TEXT, cur_x, cur_y, 0, 0, 0, c, 0);
		move_cursor(8, 0);
	endfunction

	function automatic void send_key(logic [6:0] v);
		put(C_KEY, 0, 0, 0, 0, 0, 'h80 | v, 0);
	endfunction

	function automatic void answer_query();
		case (word[6:0])
			Q_FLOW: begin
				flow_on = 1;
				send_key(7'h53);
			end
			Q_TYPE: send_key(ans_type);
			Q_SUBTYPE: send_key(ans_sub);
			Q_LOADFILE: send_key(ans_load);
			Q_CONFIG: send_key(ans_cfg);
			Q_BACKOUT: put(C_KEY, 0, 0, 0, 0, 0, 'h3FF, 0);
			Q_BEEP: put(C_BEEP, 0, 0, 0, 0, 0, 0, 0);
			Q_MEMREAD: put(C_MEMRD, 0, 0, 0, 0, mem_addr, 0, 0);
			default: send_key(word[6:0]);
		endcase
	endfunction

	function automatic void finish_item(logic [6:0] c);
		int ox, oy, dev, num;
		case (cmode)
			M_BLOCK: begin
				if (!second_pt) begin
					cur_x = coord_x();
					cur_y = coord_y();
					second_pt = 1;
				end else begin
					put(C_BLOCK, cur_x, cur_y, coord_x(), coord_y(), 0, 0, 0);
					second_pt = 0;
				end
			end
			M_POINT: begin
				cur_x = coord_x();
				cur_y = coord_y();
				put(C_DOT, cur_x, cur_y, 0, 0, 0, 0, 0);
			end
			M_LINE: begin
				if (!second_pt) begin
					cur_x = coord_x();
					cur_y = coord_y();
					second_pt = 1;
				end else begin
					ox = cur_x;
					oy = cur_y;
					cur_x = coord_x();
					cur_y = coord_y();
					put(C_LINE, ox, oy, cur_x, cur_y, 0, 0, 0);
				end
			end
			M_TEXT: text_char(c);
			M_LCOORD: begin
				cur_x = coord_x();
				cur_y = coord_y();
			end
			M_LADDR: begin
				mem_addr = word;
				row_cnt = 0;
			end
			M_SSF: begin
				dev = word[15:10];
				if (dev == 1) put(C_ALLOW, 0, 0, 0, 0, 0, {word[5], word[3]}, 0);
				else if (word[9]) put(C_SELIN, 0, 0, 0, 0, dev, !word[8], 0);
				else begin
					put(C_SELOUT, 0, 0, 0, 0, dev, 0, 0);
					if (!word[8]) put(C_EXTOUT, 0, 0, 0, 0, 0, word[7:0], 0);
				end
			end
			M_EXT: begin
				put(C_EXTOUT, 0, 0, 0, 0, 0, word[15:8], 0);
				put(C_EXTOUT, 0, 0, 0, 0, 0, word[7:0], 0);
			end
			M_ECHO: answer_query();
			M_LCHAR: begin
				rows[row_cnt] = word;
				if (row_cnt < GlyphRows - 1) row_cnt++;
				else begin
					num = ((mem_addr - font_base) & 'hFFFF) >> 4;
					for (int i = 0; i < GlyphRows; i++)
						put(C_GLYPH, 0, 0, 0, 0, num & 'h7F, rows[i], i);
					row_cnt = 0;
					mem_addr = mem_addr + 16'd16;
				end
			end
			M_LMEM: begin
				put(C_MEMLD, 0, 0, 0, 0, mem_addr, word, 0);
				mem_addr = mem_addr + 16'd2;
			end
			M_MODE5: put(C_MODE5, 0, 0, 0, 0, 0, word, 0);
			M_MODE6: put(C_MODE6, 0, 0, 0, 0, 0, word, 0);
			M_MODE7: put(C_MODE7, 0, 0, 0, 0, 0, word, 0);
			default: ;
		endcase
		cmode = pmode;
		ctype = ptype;
		ph = 0;
	endfunction

	function automatic void data_byte(logic [6:0] c);
		case (ctype)
			T_BYTE: text_char(c);
			T_WORD: begin
				if (ph == 0) begin
					word = {10'd0, c[5:0]};
					ph = 1;
				end else if (ph == 1) begin
					word[11:6] = c[5:0];
					ph = 2;
				end else begin
					word[15:12] = c[3:0];
					finish_item(c);
				end
			end
			T_COORD: begin
				case (c[6:5])
					2'd1: begin
						if (ph == 0) parts[3] = c[4:0];
						else parts[1] = c[4:0];
						ph = 1;
					end
					2'd2: begin
						parts[0] = c[4:0];
						finish_item(c);
					end
					2'd3: begin
						parts[2] = c[4:0];
						ph = 1;
					end
					default: ;
				endcase
			end
			T_COLOR: if (ph < 3) ph++; else finish_item(c);
			T_PAINT: if (ph == 0) ph = 1; else finish_item(c);
			default: ;
		endcase
	endfunction

	function automatic void escape_code(logic [6:0] c);
		if (c >= E_FONT0 && c <= E_FONT3) attr[3:2] = c - E_FONT0;
		else case (c)
			B_ETX: begin
				in_tty = 1;
				flow_on = 0;
				put(C_ENTTY, 0, 0, 0, 0, 0, 0, 0);
			end
			E_CLEAR: put(C_CLEAR, 0, 0, 0, 0, 0, 0, 0);
			E_INVERSE: attr[1:0] = 2'd3;
			E_WRITE: attr[1:0] = 2'd0;
			E_ERASE: attr[1:0] = 2'd2;
			E_REWRITE: attr[1:0] = 2'd1;
			E_LDCOORD: begin_command(M_LCOORD, T_COORD);
			E_UP: move_cursor(0, 5);
			E_DOWN: move_cursor(0, -5);
			E_ROT_OFF: attr[5] = 0;
			E_ROT_ON: attr[5] = 1;
			E_REV_OFF: attr[6] = 0;
			E_REV_ON: attr[6] = 1;
			E_BOLD_OFF: attr[4] = 0;
			E_BOLD_ON: attr[4] = 1;
			E_LDCHAR: begin_mode(M_LCHAR, T_WORD);
			E_SSF: begin_command(M_SSF, T_WORD);
			E_EXT: begin_command(M_EXT, T_WORD);
			E_LDMEM: begin_mode(M_LMEM, T_WORD);
			E_MODE5: begin_mode(M_MODE5, T_WORD);
			E_MODE6: begin_mode(M_MODE6, T_WORD);
			E_MODE7: begin_mode(M_MODE7, T_WORD);
			E_LDADDR: begin_command(M_LADDR, T_WORD);
			E_ECHO: begin_command(M_ECHO, T_WORD);
			E_MARGIN: margin_pos = attr[5] ? cur_y : cur_x;
			E_FORE: begin_command(M_FORE, T_COLOR);
			E_BACK: begin_command(M_BACK, T_COLOR);
			E_PAINT: begin_command(M_PAINT, T_PAINT);
			default: ;
		endcase
	endfunction

	function automatic void control_code(logic [6:0] c);
		case (c)
			CT_BS: move_cursor(-8, 0);
			CT_HT: move_cursor(8, 0);
			CT_LF: move_cursor(0, -16);
			CT_VT: move_cursor(0, 16);
			CT_FF: begin
				cur_x = 0;
				cur_y = 0;
				move_cursor(0, -16);
			end
			CT_CR: begin
				if (attr[5]) cur_y = margin_pos; else cur_x = margin_pos;
				move_cursor(0, -16);
			end
			CT_BLOCK: begin_mode(M_BLOCK, T_COORD);
			CT_POINT: begin_mode(M_POINT, T_COORD);
			CT_LINE: begin_mode(M_LINE, T_COORD);
			CT_TEXT: begin_mode(M_TEXT, T_BYTE);
			default: ;
		endcase
	endfunction

	function automatic void enter_plato();
		in_tty = 0;
		put(C_ENPLATO, 0, 0, 0, 0, 0, 0, 0);
		begin_mode(M_TEXT, T_BYTE);
		parts = '{0, 0, 0, 0};
		cur_x = 0;
		cur_y = 0;
		mem_addr = 0;
		row_cnt = 0;
		margin_pos = 0;
		attr = ATTR_RESET;
	endfunction

	// Works out the results of one received byte and queues them in order.
	function automatic void decode_byte(logic [6:0] c);
		decoded_t r;
		byte_results.delete();
		if (in_tty) begin
			if (!esc_seen) put(C_TTY, 0, 0, 0, 0, 0, c, 0);
			else if (c == B_STX) enter_plato();
		end else if (esc_seen) escape_code(c);
		else if (c < 7'h20) control_code(c);
		else data_byte(c);
		esc_seen = (c == B_ESC);
		if (byte_results.size() > 0) byte_results[$].lst = 1'b1;
		foreach (byte_results[i]) begin
			r = byte_results[i];
			pending_results.push_back(r);
		end
	endfunction

	function automatic void clear_state();
		scr_w = 512;
		scr_h = 512;
		ans_type = 0;
		ans_sub = 0;
		ans_load = 0;
		ans_cfg = 0;
		font_base = 0;
		in_tty = 1;
		esc_seen = 0;
		pmode = M_TEXT;
		cmode = M_TEXT;
		ptype = T_BYTE;
		ctype = T_BYTE;
		second_pt = 0;
		ph = 0;
		word = 0;
		parts = '{0, 0, 0, 0};
		cur_x = 0;
		cur_y = 0;
		margin_pos = 0;
		mem_addr = 0;
		row_cnt = 0;
		attr = ATTR_RESET;
		flow_on = 0;
		pending_results.delete();
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	initial begin
		fails = 0;
		results_due = 0;
		results_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		decoded_t w;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					R_WIDTH: scr_w = cfg_wdata[10:0];
					R_HEIGHT: scr_h = cfg_wdata[10:0];
					R_TYPE: ans_type = cfg_wdata[6:0];
					R_SUBTYPE: ans_sub = cfg_wdata[6:0];
					R_LOADFILE: ans_load = cfg_wdata[6:0];
					R_CONFIG: ans_cfg = cfg_wdata[6:0];
					R_FONTBASE: font_base = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) decode_byte(rx_byte[6:0]);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with command 0x%0h arrived with nothing expected", command);
					fails++;
				end else begin
					w = pending_results.pop_front();
					check_field("command", w.command, command);
					check_field("pos_x", w.px, pos_x);
					check_field("pos_y", w.py, pos_y);
					check_field("end_x", w.ex, end_x);
					check_field("end_y", w.ey, end_y);
					check_field("target_address", w.tgt, target_address);
					check_field("payload", w.pay, payload);
					check_field("glyph_row", w.row, glyph_row);
					check_field("attributes", w.attr, attributes);
					check_field("last", w.lst, last);
				end
			end
		end
		results_due = pending_results.size();
	end

endmodule

/* sim/tb_plato_terminal_stream_decoder_top.sv */
// Top of the decoder testbench: clock, reset, register writes, byte stimulus and receiver stalls.
// Depends on ptsd_pkg, ptsd_tb_pkg, ptsd_checker and the decoder top level.
module tb_plato_terminal_stream_decoder_top;
	import ptsd_pkg::*;
	import ptsd_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 600000;
	localparam int HoldCycles = 500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  command;
	logic [10:0] pos_x, pos_y, end_x, end_y;
	logic [15:0] target_address, payload;
	logic [2:0]  glyph_row;
	logic [6:0]  attributes;
	logic        last;

	int fails, results_due, results_seen;
	int send_idle = 0;
	int recv_idle = 0;
	int bytes_sent = 0;
	int cycles = 0;
	// The stimulus asks for a long receiver hold-off by bumping this count.
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;

	always #6 clk = ~clk;

	plato_terminal_stream_decoder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.command(command), .pos_x(pos_x), .pos_y(pos_y), .end_x(end_x), .end_y(end_y),
		.target_address(target_address), .payload(payload), .glyph_row(glyph_row),
		.attributes(attributes), .last(last)
	);

	ptsd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.command(command), .pos_x(pos_x), .pos_y(pos_y), .end_x(end_x), .end_y(end_y),
		.target_address(target_address), .payload(payload), .glyph_row(glyph_row),
		.attributes(attributes), .last(last),
		.fails(fails), .results_due(results_due), .results_seen(results_seen)
	);

	// Receiver side. A requested hold-off keeps stall high for a long stretch, counted here,
	// so that the job queue fills and the decoder has to stall its own input.
	always @(negedge clk) begin
		if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left <= HoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	// Watchdog: a hung decoder must not keep the run alive for ever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offers one byte and returns at the rising edge of its transfer. Idle gaps before the
	// byte are drawn at random; the payload is held steady while the decoder stalls.
	task automatic offer_byte(logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// A 7-bit code with the ignored top bit set at random.
	task automatic send_code(logic [6:0] c);
		offer_byte({$urandom_range(0, 1) == 1, c});
	endtask

	task automatic send_escape(logic [6:0] c);
		send_code(B_ESC);
		send_code(c);
	endtask

	// A 16-bit word in three 6-bit transfers; the spare bits of the third are random,
	// since the decoder drops them.
	task automatic send_word(logic [15:0] w);
		logic [1:0] spare;
		spare = 2'($urandom_range(0, 3));
		send_code({1'b1, w[5:0]});
		send_code({1'b1, w[11:6]});
		send_code({1'b1, spare, w[15:12]});
	endtask

	// A coordinate pair: high y, low y, high x, low x. The high parts are sometimes left out
	// so that the decoder reuses what it held.
	task automatic send_point(logic [9:0] x, logic [9:0] y);
		if ($urandom_range(0, 3) != 0) send_code({2'b01, y[9:5]});
		send_code({2'b11, y[4:0]});
		if ($urandom_range(0, 3) != 0) send_code({2'b01, x[9:5]});
		send_code({2'b10, x[4:0]});
	endtask

	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Stops offering bytes, then waits until every expected result has come, plus a margin
	// for jobs that cause none.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int w, int h, int ty, int sub, int lf, int cf, int fb);
		drain();
		write_reg(R_WIDTH, 16'(w));
		write_reg(R_HEIGHT, 16'(h));
		write_reg(R_TYPE, 16'(ty));
		write_reg(R_SUBTYPE, 16'(sub));
		write_reg(R_LOADFILE, 16'(lf));
		write_reg(R_CONFIG, 16'(cf));
		write_reg(R_FONTBASE, 16'(fb));
	endtask

	// One random protocol sequence. Most are well formed with random content; the rest are
	// stray bytes, cut-off assemblies and trips through TTY mode.
	task automatic random_sequence();
		int n;
		logic [6:0] esc_codes[] = '{E_CLEAR, E_INVERSE, E_WRITE, E_ERASE, E_REWRITE, E_UP,
			E_DOWN, E_FONT0, E_FONT3, E_ROT_OFF, E_ROT_ON, E_REV_OFF, E_REV_ON, E_BOLD_OFF,
			E_BOLD_ON, E_MARGIN};
		logic [6:0] ctl_codes[] = '{CT_BS, CT_HT, CT_LF, CT_VT, CT_FF, CT_CR};
		logic [6:0] queries[] = '{Q_FLOW, Q_TYPE, Q_SUBTYPE, Q_LOADFILE, Q_CONFIG, Q_BACKOUT,
			Q_BEEP, Q_MEMREAD};
		case ($urandom_range(0, 15))
			0, 1: begin
				n = $urandom_range(1, 6);
				repeat (n) send_code(7'($urandom_range(7'h20, 7'h7F)));
			end
			2: send_code(ctl_codes[$urandom_range(0, ctl_codes.size() - 1)]);
			3: send_escape(esc_codes[$urandom_range(0, esc_codes.size() - 1)]);
			4: begin
				send_code($urandom_range(0, 1) ? CT_LINE : CT_BLOCK);
				n = $urandom_range(1, 4);
				repeat (n) send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
				send_code(CT_TEXT);
			end
			5: begin
				send_code(CT_POINT);
				send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
				send_code(CT_TEXT);
			end
			6: begin
				send_escape(E_LDCOORD);
				send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			end
			7: begin
				send_escape(E_LDADDR);
				send_word(random_word());
				send_escape(E_LDCHAR);
				repeat (GlyphRows) send_word(random_word());
				send_code(CT_TEXT);
			end
			8: begin
				send_escape(E_LDMEM);
				n = $urandom_range(1, 3);
				repeat (n) send_word(random_word());
				send_code(CT_TEXT);
			end
			9: begin
				send_escape(7'($urandom_range(E_MODE5, E_MODE7)));
				send_word(random_word());
				send_code(CT_TEXT);
			end
			10: begin
				send_escape($urandom_range(0, 1) ? E_SSF : E_EXT);
				send_word(random_word());
			end
			11: begin
				send_escape(E_ECHO);
				if ($urandom_range(0, 3) == 0) send_word(random_word());
				else send_word({9'($urandom_range(0, 511)), queries[$urandom_range(0, 7)]});
			end
			12: begin
				send_escape(7'($urandom_range(E_FORE, E_PAINT)));
				n = $urandom_range(2, 4);
				repeat (n) send_code(7'($urandom_range(7'h20, 7'h7F)));
			end
			13: begin
				// A word command cut short by a mode change.
				send_escape(E_MODE5);
				send_code(7'($urandom_range(7'h40, 7'h7F)));
				send_code($urandom_range(0, 1) ? CT_LINE : CT_TEXT);
			end
			14: begin
				send_escape(B_ETX);
				n = $urandom_range(0, 4);
				repeat (n) offer_byte(8'($urandom_range(0, 255)));
				send_escape(B_STX);
			end
			default: offer_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic random_phase(int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target) random_sequence();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: TTY pass-through, the ignored top bit, an escape ignored in TTY
		// mode, the switch to PLATO, text with every cursor attribute, a flow echo query, and the way back.
		offer_byte(8'h41);
		offer_byte(8'hFF);
		send_escape(7'h05);
		send_escape(B_STX);
		send_code(7'h20);
		send_code(7'h7F);
		send_escape(E_BOLD_ON);
		send_escape(E_REV_ON);
		send_code(7'h41);
		send_escape(E_ROT_ON);
		send_code(CT_CR);
		send_code(7'h42);
		send_escape(E_ECHO);
		send_word({9'd0, Q_FLOW});
		send_escape(B_ETX);
		send_escape(B_STX);
		drain();

		// Sender mostly busy, receiver mostly stalled; one long hold-off fills the queue.
		configure(1, 1024, 127, 0, 85, 42, 16'hFFFF);
		send_idle = 16;
		recv_idle = 74;
		hold_asked++;
		random_phase(160);

		configure(1024, 1, 0, 127, 0, 127, 16'h1230);
		send_idle = 74;
		recv_idle = 16;
		random_phase(150);

		configure($urandom_range(2, 1023), $urandom_range(2, 1023), $urandom_range(0, 127),
			$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 65535));
		send_idle = 0;
		recv_idle = 0;
		random_phase(150);

		drain();

		$display("Sent %0d bytes over four register settings, checked %0d results.",
			bytes_sent, results_seen);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
